@@ hw/rtl/firq15_pkg.sv @@
// Shared types, widths and constants of the Q15 direct-form FIR filter.
package firq15_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned ROUND_SHIFT  = 15;
  localparam logic [ACC_W-1:0] ROUND_K = 32'h0000_4000;
  localparam int unsigned TAPS_DEFAULT = 64;

  // Input tdata layout: sample_in, tap_index, tap_value, zero padding
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // Mode carried in tuser
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } fir_state_e;

  // Control broadcast to every cell of the tap chain
  typedef struct packed {
    logic                shift;
    logic                rotate;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [SAMPLE_W-1:0] wr_val;
  } cell_ctl_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

endpackage

@@ hw/rtl/firq15_cell.sv @@
// One tap cell: holds one delayed sample and one coefficient of the chain.
module firq15_cell import firq15_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [SAMPLE_W-1:0] shift_smp_i,
  input  logic [SAMPLE_W-1:0] rot_smp_i,
  input  logic [SAMPLE_W-1:0] rot_coef_i,
  output logic [SAMPLE_W-1:0] smp_o,
  output logic [SAMPLE_W-1:0] coef_o
);

  localparam bit ADDRESSABLE = (IDX < (1 << IDX_W));

  logic [SAMPLE_W-1:0] smp_q;
  logic [SAMPLE_W-1:0] coef_q;
  logic                wr_hit;

  assign wr_hit = ADDRESSABLE && ctl_i.wr_en && (ctl_i.wr_idx == IDX_W'(IDX));

  // Advance the delay line on a new sample, rotate it during the pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (ctl_i.shift) begin
      smp_q <= shift_smp_i;
    end else if (ctl_i.rotate) begin
      smp_q <= rot_smp_i;
    end
  end

  // Load the coefficient on a matching write, rotate it during the pass
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      coef_q <= ctl_i.wr_val;
    end else if (ctl_i.rotate) begin
      coef_q <= rot_coef_i;
    end
  end

  assign smp_o  = smp_q;
  assign coef_o = coef_q;

endmodule

@@ hw/rtl/firq15_mac.sv @@
// Shared multiply-accumulate unit with Q15 rounding of the final sum.
module firq15_mac import firq15_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mac_ctl_t            ctl_i,
  input  logic [SAMPLE_W-1:0] coef_i,
  input  logic [SAMPLE_W-1:0] smp_i,
  output logic [SAMPLE_W-1:0] result_o
);

  logic signed [ACC_W-1:0] prod_q;
  logic                    prod_vld_q;
  logic        [ACC_W-1:0] acc_q;
  logic        [ACC_W-1:0] rnd;

  // Register the product of the head cell
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= $signed(coef_i) * $signed(smp_i);
    end
  end

  // Track whether the product register holds a term to add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
    end
  end

  // Accumulate modulo 2^32
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round, shift right arithmetically and keep the low bits
  assign rnd      = acc_q + ROUND_K;
  assign result_o = rnd[ROUND_SHIFT+SAMPLE_W-1:ROUND_SHIFT];

endmodule

@@ hw/rtl/fir_filter_q15.sv @@
// Top level of the Q15 direct-form FIR filter: tap chain, MAC and control.
//
// Input channel s_axis: tuser selects the beat kind. tuser = 0 carries a
// sample in tdata[15:0] and yields one output beat; tuser = 1 writes the
// coefficient tdata[37:22] to tap tdata[21:16] and yields no output.
// Tap indexes at or above TAPS are ignored. Load coefficients first.
// Output channel m_axis: tdata[15:0] is the rounded Q15 filtered sample.
// Each cell of the tap chain holds one delayed sample and one coefficient.
// A sample beat shifts the chain by one cell; the chain then rotates once
// around while the head cell feeds one shared registered multiplier and
// accumulator, so the ring is back in place at the end.
// The sum passes through the MAC, DRAIN and DONE states into the output register.
// No new sample is taken before the pass is over, as set by the single MAC pass.
// Coefficient beats are taken back to back while the block is idle.
// s_axis_tready is high only between passes. A stalled output beat is held
// in the output register; a finished pass then waits for that register.
// Reset clears the delay line and the control; coefficients are kept only
// once written.
module fir_filter_q15 import firq15_pkg::*; #(
  parameter int unsigned TAPS = TAPS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_in[15:0], tap_index[21:16],
                                               // tap_value[37:22], zero pad [39:38]
  input  logic                  s_axis_tuser,  // mode[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // sample_out[15:0]
);

  localparam int unsigned CW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(TAPS - 1);

  fir_state_e  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        s_acc;
  logic        rotate;
  logic        load_out;
  cell_ctl_t   cell_ctl;
  mac_ctl_t    mac_ctl;

  logic [SAMPLE_W-1:0] smp  [TAPS];
  logic [SAMPLE_W-1:0] coef [TAPS];
  logic [SAMPLE_W-1:0] result;

  logic                out_vld_q;
  logic [SAMPLE_W-1:0] out_data_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Broadcast control to the chain
  always_comb begin
    cell_ctl.shift  = s_acc && (s_axis_tuser == MODE_FILTER);
    cell_ctl.rotate = rotate;
    cell_ctl.wr_en  = s_acc && (s_axis_tuser == MODE_COEF);
    cell_ctl.wr_idx = s_axis_tdata[21:16];
    cell_ctl.wr_val = s_axis_tdata[37:22];
  end

  // Tap chain: shift from the left, rotate from the right
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % TAPS;
    logic [SAMPLE_W-1:0] shift_in;
    if (i == 0) begin : g_head
      assign shift_in = s_axis_tdata[SAMPLE_W-1:0];
    end else begin : g_body
      assign shift_in = smp[i-1];
    end
    firq15_cell #(.IDX(i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .shift_smp_i (shift_in),
      .rot_smp_i   (smp[NXT]),
      .rot_coef_i  (coef[NXT]),
      .smp_o       (smp[i]),
      .coef_o      (coef[i])
    );
  end

  firq15_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .coef_i   (coef[0]),
    .smp_i    (smp[0]),
    .result_o (result)
  );

  // State and tap counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Sequence one pass over the chain per sample
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    rotate         = 1'b0;
    load_out       = 1'b0;
    mac_ctl.clear  = 1'b0;
    mac_ctl.mul_en = 1'b0;
    s_axis_tready  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == MODE_FILTER)) begin
          mac_ctl.clear = 1'b1;
          cnt_d         = '0;
          state_d       = ST_MAC;
        end
      end
      ST_MAC: begin
        rotate         = 1'b1;
        mac_ctl.mul_en = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/firq15_checker.sv @@
// Port-level checker of the Q15 FIR filter and its bind to the top level.
module firq15_checker import firq15_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // No output beat is pending while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // A stalled output beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

  // A sample beat starts a pass, which blocks further input
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser == MODE_FILTER)) |=> !s_axis_tready)
    else $error("input accepted during a filter pass");

  // A coefficient beat keeps the block ready for the next beat
  a_coef_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser == MODE_COEF)) |=> s_axis_tready)
    else $error("coefficient write stalled the input");

  // A new output beat only appears at the end of a pass
  a_out_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output beat without a filter pass");

endmodule

bind fir_filter_q15 firq15_checker u_firq15_checker (.*);

@@ tb/sv/fir_filter_q15_tb.sv @@
// Self-checking testbench of the Q15 direct-form FIR filter, with its own tap predictor.
module fir_filter_q15_tb;
  import firq15_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAPS      = TAPS_DEFAULT;
  localparam int unsigned CYC_LIMIT = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = MODE_FILTER;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Mirror of the block: coefficients and delayed samples
  logic signed [SAMPLE_W-1:0] coef_mirror [TAPS];
  logic signed [SAMPLE_W-1:0] hist_mirror [TAPS] = '{default: '0};

  logic [OUT_DATA_W-1:0] filtered_q [$];
  logic [OUT_DATA_W-1:0] want;

  bit          gaps_on = 1'b1;
  int unsigned cycles, n_errors, n_checked, n_coef, n_samples;

  fir_filter_q15 #(.TAPS(TAPS)) i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the rounded output for one sample and advance the delay line
  function automatic logic [OUT_DATA_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] smp);
    logic [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0] prod;
    acc = '0;
    hist_mirror[0] = smp;
    for (int k = 0; k < TAPS; k++) begin
      prod = coef_mirror[k] * hist_mirror[k];
      acc  = acc + prod;
    end
    for (int k = TAPS - 1; k >= 1; k--) hist_mirror[k] = hist_mirror[k-1];
    acc = acc + ROUND_K;
    return OUT_DATA_W'($signed(acc) >>> ROUND_SHIFT);
  endfunction

  // Random Q15 value, leaning on the extremes now and then
  function automatic logic [SAMPLE_W-1:0] rand_q15();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Send one beat, then update the mirror once it is taken
  task automatic push_beat(input logic mode, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    while (gaps_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(IN_DATA_W-38){1'b0}}, val, idx, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == MODE_COEF) begin
      if (idx < TAPS) coef_mirror[idx] = val;
      n_coef++;
    end else begin
      filtered_q.push_back(filter_sample(smp));
      n_samples++;
    end
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
    push_beat(MODE_FILTER, smp, IDX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic push_coef(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    push_beat(MODE_COEF, SAMPLE_W'($urandom), idx, val);
  endtask

  // Hold off the sender until every pending output has come back
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  // Load every tap: eight chosen values at the head, zeros behind
  task automatic test_load_taps();
    logic [SAMPLE_W-1:0] head [8] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001,
                                      16'h4000, 16'hc000, 16'h3039, 16'h7fff};
    for (int k = 0; k < TAPS; k++) push_coef(IDX_W'(k), (k < 8) ? head[k] : 16'h0000);
  endtask

  // Walk an impulse of both signs through the loaded taps
  task automatic test_impulse();
    push_sample(16'h7fff);
    for (int k = 0; k < 8; k++) push_sample(16'h0000);
    push_sample(16'h8000);
    push_sample(16'h0001);
    push_sample(16'hffff);
  endtask

  // Drive the accumulator and the output past their ranges
  task automatic test_overflow();
    for (int k = 0; k < 8; k++) push_coef(IDX_W'(k), 16'h8000);
    for (int k = 0; k < 8; k++) push_sample(16'h8000);
    push_coef(6'd63, 16'h7fff);
    push_coef(6'd0, 16'h7fff);
    for (int k = 0; k < 4; k++) push_sample(16'h7fff);
  endtask

  // Random mix of coefficient writes and samples
  task automatic test_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) push_coef(IDX_W'($urandom_range(TAPS - 1)), rand_q15());
      else                         push_sample(rand_q15());
    end
  endtask

  // Back-to-back traffic: no sender gaps and the receiver always ready
  task automatic test_no_gaps(input int unsigned count);
    gaps_on = 1'b0;
    test_random(count);
    gaps_on = 1'b1;
  endtask

  // Receiver: stall at random unless gaps are switched off
  always @(posedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 13) : 1'b1;
  end

  // Compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, want, m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYC_LIMIT) begin
      $display("%0t: timeout with %0d outputs pending", $time, filtered_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // Assert reset with a falling edge so the block clears before the first clock
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_taps();
    test_impulse();
    test_overflow();
    test_random(900);
    drain_outputs();
    test_no_gaps(200);
    test_random(800);

    // Let the last pass finish, then allow time for any stray beat
    drain_outputs();
    repeat (TAPS + 8) @(posedge clk_i);

    $display("Run covered %0d coefficient writes and %0d samples, %0d outputs checked,",
             n_coef, n_samples, n_checked);
    $display("including impulses, full-scale taps and wrapping sums; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
